// ===== sv/rgb_point_operation_unit_defines.svh =====
// Assertion macros for the RGB point operation unit.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef RGB_POINT_OPERATION_UNIT_DEFINES_SVH
`define RGB_POINT_OPERATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RPOU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpou: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RPOU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpou: next-cycle check failed");

`endif

// ===== sv/rpou_pkg.sv =====
// Shared types and constants for the RGB point operation unit.
// Used by the lane, merge and top-level modules; depends on nothing.
`default_nettype none

package rpou_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned GAIN_W   = 11;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned NUM_CH   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY     = 3'd0,
    MODE_SEPIA    = 3'd1,
    MODE_INVERT   = 3'd2,
    MODE_CONTRAST = 3'd3,
    MODE_BRIGHT   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GAIN   = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_e;

  typedef logic [9:0] coef_t;
  typedef coef_t coef_row_t [NUM_CH];

  // Sepia matrix in Q10, one row per output channel.
  localparam coef_row_t SEPIA_Q10 [NUM_CH] = '{
    '{10'd402, 10'd787, 10'd194},
    '{10'd357, 10'd702, 10'd172},
    '{10'd279, 10'd547, 10'd134}
  };

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offset;
  } lane_cfg_t;

endpackage

`default_nettype wire

// ===== sv/rgb_point_operation_unit.sv =====
// RGB point operation unit top level: configuration registers, pipeline control,
// three channel lanes and the merge stage. Depends on rpou_pkg, rpou_lane and
// rpou_merge, and takes its assertion macros from the defines header.
//
// Usage:
//   Input channel: in_valid_i with chan_a_i, chan_b_i and chan_c_i; an item is
//   taken at a rising edge where in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o with out_a_o, out_b_o and out_c_o; an item is
//   delivered at a rising edge where out_valid_o is high and out_stall_i is low.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 mode, 1 contrast gain, 2 brightness offset); other indexes are ignored.
//   The three lanes register their channel results in the lane stage, and the
//   merge stage registers the pixel. Throughput is one item per cycle while the
//   output is not stalled; each stage holds one item and moves on when the
//   stage after it is empty or emptying.
//   A stalled output holds its item; further items fill the lane stage and
//   in_stall_o rises only once both stages are full and the output is stalled.
//   Reset empties both stages and sets mode to grayscale, gain to 256 and the
//   offset to zero.
`default_nettype none

`include "rgb_point_operation_unit_defines.svh"

module rgb_point_operation_unit import rpou_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CH_W-1:0]     chan_a_i,
  input  wire logic [CH_W-1:0]     chan_b_i,
  input  wire logic [CH_W-1:0]     chan_c_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [CH_W-1:0]     out_a_o,
  output logic      [CH_W-1:0]     out_b_o,
  output logic      [CH_W-1:0]     out_c_o
);

  logic [MODE_W-1:0]   mode_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [MODE_W-1:0]   mode1_q;
  logic                v1_q, v1_d;
  logic                v2_q, v2_d;
  logic                adv1, adv2, load1, load2;
  lane_cfg_t           lane_cfg;
  logic [CH_W-1:0]     chan [NUM_CH];
  logic [CH_W-1:0]     lane_res [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_GRAY;
      gain_q   <= 11'd256;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_OFFSET: offset_q <= cfg_data_i[OFFSET_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    adv2  = !v2_q || !out_stall_i;
    adv1  = !v1_q || adv2;
    load1 = in_valid_i && adv1;
    load2 = v1_q && adv2;
    v1_d  = adv1 ? in_valid_i : v1_q;
    v2_d  = adv2 ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      mode1_q <= mode_q;
    end
  end

  assign lane_cfg = '{mode: mode_q, gain: gain_q, offset: offset_q};
  assign chan[0]  = chan_a_i;
  assign chan[1]  = chan_b_i;
  assign chan[2]  = chan_c_i;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    rpou_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (load1),
      .cfg_i    (lane_cfg),
      .coef_i   (SEPIA_Q10[g]),
      .chan_a_i (chan_a_i),
      .chan_b_i (chan_b_i),
      .chan_c_i (chan_c_i),
      .own_i    (chan[g]),
      .res_o    (lane_res[g])
    );
  end

  rpou_merge u_merge (
    .clk_i    (clk_i),
    .load_i   (load2),
    .mode_i   (mode1_q),
    .lane_a_i (lane_res[0]),
    .lane_b_i (lane_res[1]),
    .lane_c_i (lane_res[2]),
    .out_a_o  (out_a_o),
    .out_b_o  (out_b_o),
    .out_c_o  (out_c_o)
  );

  assign in_stall_o  = !adv1;
  assign out_valid_o = v2_q;

  `RPOU_ASSERT_NOW(a_stall_only_when_full, in_stall_o, v1_q && out_valid_o && out_stall_i)
  `RPOU_ASSERT_NEXT(a_accept_fills_lanes, in_valid_i && !in_stall_o, v1_q)
  `RPOU_ASSERT_NEXT(a_lanes_drain, v1_q && !out_valid_o, out_valid_o)
  `RPOU_ASSERT_NEXT(a_output_holds, out_valid_o && out_stall_i, out_valid_o)

endmodule

`default_nettype wire

// ===== sv/rpou_lane.sv =====
// One channel lane: grayscale pass-through, sepia row, invert, contrast and brightness for one byte.
// Depends on rpou_pkg; the result is registered when load_i is high.
`default_nettype none

module rpou_lane import rpou_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            load_i,
  input  wire lane_cfg_t       cfg_i,
  input  wire coef_row_t       coef_i,
  input  wire logic [CH_W-1:0] chan_a_i,
  input  wire logic [CH_W-1:0] chan_b_i,
  input  wire logic [CH_W-1:0] chan_c_i,
  input  wire logic [CH_W-1:0] own_i,
  output logic      [CH_W-1:0] res_o
);

  logic [18:0]        sep_sum;
  logic [8:0]         sep_px;
  logic [CH_W-1:0]    sep_res;
  logic signed [9:0]  diff;
  logic signed [21:0] con_prod;
  logic signed [21:0] con_t;
  logic [11:0]        con_q;
  logic [CH_W-1:0]    con_res;
  logic signed [9:0]  bri_sum;
  logic [CH_W-1:0]    bri_res;
  logic [CH_W-1:0]    res_d;
  logic [CH_W-1:0]    res_q;

  always_comb begin
    sep_sum = 19'(coef_i[0]) * 19'(chan_a_i) + 19'(coef_i[1]) * 19'(chan_b_i)
            + 19'(coef_i[2]) * 19'(chan_c_i);
    sep_px  = sep_sum[18:10];
    sep_res = sep_px[8] ? 8'hFF : sep_px[7:0];
  end

  always_comb begin
    diff     = $signed({1'b0, own_i, 1'b0}) - 10'sd255;
    con_prod = $signed({{12{diff[9]}}, diff}) * $signed({11'b0, cfg_i.gain});
    con_t    = con_prod + 22'sd65280;
    con_q    = con_t[20:9];
    if (con_t[21]) begin
      con_res = '0;
    end else if (|con_q[11:8]) begin
      con_res = 8'hFF;
    end else begin
      con_res = con_q[7:0];
    end
  end

  always_comb begin
    bri_sum = $signed({2'b00, own_i}) + $signed({cfg_i.offset[8], cfg_i.offset});
    if (bri_sum[9]) begin
      bri_res = '0;
    end else if (bri_sum[8]) begin
      bri_res = 8'hFF;
    end else begin
      bri_res = bri_sum[7:0];
    end
  end

  // Grayscale passes the byte on; the merge stage forms the average.
  always_comb begin
    case (cfg_i.mode)
      MODE_SEPIA:    res_d = sep_res;
      MODE_INVERT:   res_d = ~own_i;
      MODE_CONTRAST: res_d = con_res;
      MODE_BRIGHT:   res_d = bri_res;
      default:       res_d = own_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== sv/rpou_merge.sv =====
// Merge stage: combines the three lane results into the output pixel.
// Depends on rpou_pkg; forms the grayscale average and holds the output register.
`default_nettype none

module rpou_merge import rpou_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [CH_W-1:0]   lane_a_i,
  input  wire logic [CH_W-1:0]   lane_b_i,
  input  wire logic [CH_W-1:0]   lane_c_i,
  output logic      [CH_W-1:0]   out_a_o,
  output logic      [CH_W-1:0]   out_b_o,
  output logic      [CH_W-1:0]   out_c_o
);

  logic [9:0]      sum;
  logic [19:0]     recip;
  logic [CH_W-1:0] gray;
  logic [CH_W-1:0] out_a_d, out_b_d, out_c_d;
  logic [CH_W-1:0] out_a_q, out_b_q, out_c_q;

  // Division by three as a multiplication by 683 / 2048, exact for sums up to 765.
  always_comb begin
    sum   = 10'(lane_a_i) + 10'(lane_b_i) + 10'(lane_c_i);
    recip = 20'(sum) * 20'd683;
    gray  = recip[18:11];
  end

  always_comb begin
    if (mode_i == MODE_GRAY) begin
      out_a_d = gray;
      out_b_d = gray;
      out_c_d = gray;
    end else begin
      out_a_d = lane_a_i;
      out_b_d = lane_b_i;
      out_c_d = lane_c_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_a_q <= out_a_d;
      out_b_q <= out_b_d;
      out_c_q <= out_c_d;
    end
  end

  assign out_a_o = out_a_q;
  assign out_b_o = out_b_q;
  assign out_c_o = out_c_q;

endmodule

`default_nettype wire
